/* hdl/iclod_pkg.sv */
// ----------------------------------------------------------------------------
// Instance cull and detail-level package
// Field widths, register indexes, codes and fixed-point constants of the block.
// ----------------------------------------------------------------------------
package iclod_pkg;

  // Item field widths.
  localparam int COORD_W     = 40;
  localparam int RADIUS_W    = 39;
  localparam int SLOT_W      = 5;
  localparam int LAYER_W     = 3;
  localparam int LOD_BITS    = 2;
  localparam int VERDICT_W   = 2;
  localparam int MASK_W      = 8;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 40;

  localparam logic [CFG_INDEX_W-1:0] REG_CAMERA_X      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CAMERA_Y      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CAMERA_Z      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_VIEW_DISTANCE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LAYER_MASK    = 3'd4;

  localparam logic [RADIUS_W-1:0] VIEW_DIST_RESET  = 39'd327680000;
  localparam logic [MASK_W-1:0]   LAYER_MASK_RESET = 8'hFF;

  // Fixed-point format and layer count.
  localparam int          FRAC_BITS = 16;
  localparam int unsigned LAYERS    = 8;

  // Plane store layout: four words per plane, normal x, y, z, then offset.
  localparam int PLANES      = 6;
  localparam int PLANE_COMPS = 4;
  localparam int OFFSET_COMP = 3;
  localparam int PLANE_WORDS = PLANES * PLANE_COMPS;

  // Item opcodes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_VISIBLE = 2'd0,
    VERDICT_LAYER   = 2'd1,
    VERDICT_FAR     = 2'd2,
    VERDICT_FRUSTUM = 2'd3
  } verdict_t;

  // Pipeline depth from accepted instance to offered result.
  localparam int PIPE_STAGES = 7;

  // Datapath widths. Multiplier operands hold a 41-bit magnitude as a signed value.
  localparam int MUL_W  = COORD_W + 2;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DIST_W = PROD_W;
  localparam int D2_W   = 2 * (COORD_W + 1);
  localparam int RR_W   = 2 * RADIUS_W;
  // 2500 * r^2 needs twelve more bits than r^2; 100 * d2 fits in the same width.
  localparam int LOD_W  = RR_W + 12;

  // Detail-level weights: r^2 * 2500 is compared against m * 100, m * 9 and m.
  localparam int LOD_RR_K = 2500;
  localparam int LOD_K0   = 100;
  localparam int LOD_K1   = 9;

  // Distance floor of 1e-4 in the squared format, rounded half up.
  localparam logic [63:0] LOD_FLOOR =
    ((64'd1 << (2 * FRAC_BITS)) + 64'd5000) / 64'd10000;
  localparam logic [63:0] LOD_FLOOR_K0 = LOD_FLOOR * 64'd100;
  localparam logic [63:0] LOD_FLOOR_K1 = LOD_FLOOR * 64'd9;

endpackage

/* hdl/iclod_if.sv */
// ----------------------------------------------------------------------------
// Instance cull channel interfaces
// Valid/ready channels for instance items and for cull results.
// ----------------------------------------------------------------------------
interface iclod_inst_if;
  import iclod_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [SLOT_W-1:0]          plane_slot;
  logic signed [COORD_W-1:0]  plane_word;
  logic signed [COORD_W-1:0]  center_x;
  logic signed [COORD_W-1:0]  center_y;
  logic signed [COORD_W-1:0]  center_z;
  logic [RADIUS_W-1:0]        radius;
  logic [LAYER_W-1:0]         layer;
  logic [LOD_BITS-1:0]        max_lod;

  modport source (
    output valid, opcode, plane_slot, plane_word, center_x, center_y, center_z,
    output radius, layer, max_lod,
    input  ready
  );

  modport sink (
    input  valid, opcode, plane_slot, plane_word, center_x, center_y, center_z,
    input  radius, layer, max_lod,
    output ready
  );
endinterface

interface iclod_result_if;
  import iclod_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 visible;
  logic [LOD_BITS-1:0]  lod;
  logic [VERDICT_W-1:0] verdict;

  modport source (output valid, visible, lod, verdict, input ready);
  modport sink (input valid, visible, lod, verdict, output ready);
endinterface

/* hdl/instance_cull_lod_select_unit.sv */
// ----------------------------------------------------------------------------
// Instance cull and detail-level select unit
// Sphere test against layer mask, view distance and six frustum planes.
// ----------------------------------------------------------------------------
// Items arrive on inst. A load item (opcode 0) with a slot below 24 writes
// one plane word at once and yields no result; a test item (opcode 1) yields
// one transaction on result with visible, lod and verdict. Camera position,
// view distance and the layer mask come from the write port cfg_we /
// cfg_index / cfg_data. They must be changed only while no test is in flight;
// the block itself does not enforce this. Throughput is one item per cycle
// while result is not stalled. The item passes seven registers: one input
// register, two stages for each 42-bit multiply (partial products, then their
// sum), two adder stages for the plane and distance sums, one compare stage
// and the output register.
// Stages hold their own valid bits and advance into any empty slot, so inst
// keeps accepting while result is stalled until all seven stages are full;
// nothing is dropped or repeated.
// Reset empties the pipeline, clears all plane words to zero and sets the
// registers to camera at origin, view distance 5000.0 and all layers shown.
// ----------------------------------------------------------------------------
module instance_cull_lod_select_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [iclod_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [iclod_pkg::CFG_DATA_W-1:0]  cfg_data,
  iclod_inst_if.sink                        inst,
  iclod_result_if.source                    result
);
  import iclod_pkg::*;

  localparam int SIDE = PIPE_STAGES - 1;

  // Configuration and plane state.
  logic signed [COORD_W-1:0] camera [3];
  logic [RADIUS_W-1:0]       view_distance;
  logic [MASK_W-1:0]         layer_mask;
  logic signed [COORD_W-1:0] plane_store [PLANE_WORDS];

  // Pipeline control.
  logic [PIPE_STAGES-1:0] vld;
  logic [PIPE_STAGES-1:0] adv;
  logic                   take_test;
  logic                   take_load;

  // Input side.
  logic signed [COORD_W-1:0] center_in [3];
  logic signed [COORD_W:0]   diff_in [3];
  logic [COORD_W:0]          mag_in [3];
  logic                      hidden_in;

  // Stage 0.
  logic signed [COORD_W-1:0] center0 [3];
  logic [COORD_W:0]          mag0 [3];
  logic [RADIUS_W-1:0]       radius0;

  // Side data carried through stages 0 to 5.
  logic                hid [SIDE];
  logic [LOD_BITS-1:0] mlod [SIDE];

  // Stages 1 and 2.
  logic signed [DIST_W-1:0] offr1 [PLANES];
  logic signed [DIST_W-1:0] offr2 [PLANES];
  logic signed [PROD_W-1:0] plane_prod [PLANES][3];
  logic signed [PROD_W-1:0] sq_prod [3];
  logic signed [PROD_W-1:0] rr_prod;
  logic signed [PROD_W-1:0] vd_prod;

  // Stage 3.
  logic signed [DIST_W-1:0] dist_a3 [PLANES];
  logic signed [DIST_W-1:0] dist_b3 [PLANES];
  logic [D2_W-1:0]          d2a3;
  logic [D2_W-1:0]          d2z3;
  logic [D2_W-1:0]          lim3;
  logic [RR_W-1:0]          rr3;
  logic signed [DIST_W-1:0] dist_sum [PLANES];
  logic                     outside_any;

  // Stage 4.
  logic            outside4;
  logic [D2_W-1:0] d2_4;
  logic [D2_W-1:0] lim4;
  logic [RR_W-1:0] rr4;

  // Stage 5.
  logic             outside5;
  logic             far5;
  logic             above5;
  logic [D2_W-1:0]  d2_5;
  logic [LOD_W-1:0] d_k0_5;
  logic [LOD_W-1:0] d_k1_5;
  logic [LOD_W-1:0] rr_k_5;

  // Stage 6, the output register.
  logic                res_visible;
  logic [LOD_BITS-1:0] res_lod;
  verdict_t            res_verdict;

  logic [LOD_W-1:0]    m_k0;
  logic [LOD_W-1:0]    m_k1;
  logic [LOD_W-1:0]    m_one;
  logic [LOD_BITS-1:0] level;
  logic [LOD_BITS-1:0] lod_next;
  verdict_t            verdict_next;

  // --------------------------------------------------------------------------
  // Handshake: a stage moves when it is empty or the stage after it moves.
  // --------------------------------------------------------------------------
  always_comb begin
    adv[PIPE_STAGES-1] = !vld[PIPE_STAGES-1] || result.ready;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign inst.ready = adv[0];
  assign take_test  = inst.valid && adv[0] && (inst.opcode == OP_TEST);
  assign take_load  = inst.valid && adv[0] && (inst.opcode == OP_LOAD) &&
                      (inst.plane_slot < SLOT_W'(PLANE_WORDS));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= take_test;
      end
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Configuration registers and plane store.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < 3; j++) begin
        camera[j] <= '0;
      end
      view_distance <= VIEW_DIST_RESET;
      layer_mask    <= LAYER_MASK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAMERA_X:      camera[0]     <= $signed(cfg_data);
        REG_CAMERA_Y:      camera[1]     <= $signed(cfg_data);
        REG_CAMERA_Z:      camera[2]     <= $signed(cfg_data);
        REG_VIEW_DISTANCE: view_distance <= cfg_data[RADIUS_W-1:0];
        REG_LAYER_MASK:    layer_mask    <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // A test still in stage 0 reads the planes as it leaves, before a load
  // accepted at the same edge lands, so tests see loads in arrival order.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < PLANE_WORDS; w++) begin
        plane_store[w] <= '0;
      end
    end else if (take_load) begin
      plane_store[inst.plane_slot] <= inst.plane_word;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: capture, camera-relative magnitudes and the layer check.
  // --------------------------------------------------------------------------
  always_comb begin
    center_in[0] = inst.center_x;
    center_in[1] = inst.center_y;
    center_in[2] = inst.center_z;
    for (int j = 0; j < 3; j++) begin
      diff_in[j] = (COORD_W+1)'(center_in[j]) - (COORD_W+1)'(camera[j]);
      mag_in[j]  = diff_in[j][COORD_W] ? $unsigned(-diff_in[j]) : $unsigned(diff_in[j]);
    end
    // Layers at or above the layer count are always hidden.
    hidden_in = (32'(inst.layer) >= LAYERS) || !layer_mask[inst.layer];
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int j = 0; j < 3; j++) begin
        center0[j] <= center_in[j];
        mag0[j]    <= mag_in[j];
      end
      radius0 <= inst.radius;
      hid[0]  <= hidden_in;
      mlod[0] <= inst.max_lod;
    end
    for (int k = 1; k < SIDE; k++) begin
      if (adv[k]) begin
        hid[k]  <= hid[k-1];
        mlod[k] <= mlod[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 1 and 2: products.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < PLANES; i++) begin : g_plane
    for (genvar j = 0; j < 3; j++) begin : g_axis
      iclod_mul u_mul (
        .clk     (clk),
        .en_part (adv[1]),
        .en_sum  (adv[2]),
        .a       (MUL_W'(plane_store[PLANE_COMPS*i + j])),
        .b       (MUL_W'(center0[j])),
        .p       (plane_prod[i][j])
      );
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_square
    iclod_mul u_mul (
      .clk     (clk),
      .en_part (adv[1]),
      .en_sum  (adv[2]),
      .a       (MUL_W'($signed({1'b0, mag0[j]}))),
      .b       (MUL_W'($signed({1'b0, mag0[j]}))),
      .p       (sq_prod[j])
    );
  end

  iclod_mul u_mul_rr (
    .clk     (clk),
    .en_part (adv[1]),
    .en_sum  (adv[2]),
    .a       (MUL_W'($signed({1'b0, radius0}))),
    .b       (MUL_W'($signed({1'b0, radius0}))),
    .p       (rr_prod)
  );

  iclod_mul u_mul_vd (
    .clk     (clk),
    .en_part (adv[1]),
    .en_sum  (adv[2]),
    .a       (MUL_W'($signed({1'b0, view_distance}))),
    .b       (MUL_W'($signed({1'b0, view_distance}))),
    .p       (vd_prod)
  );

  // Plane offset plus radius, scaled up to the product format.
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int i = 0; i < PLANES; i++) begin
        offr1[i] <= (DIST_W'(plane_store[PLANE_COMPS*i + OFFSET_COMP]) +
                     DIST_W'($signed({1'b0, radius0}))) <<< FRAC_BITS;
      end
    end
    if (adv[2]) begin
      for (int i = 0; i < PLANES; i++) begin
        offr2[i] <= offr1[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 3 and 4: plane distances and squared camera distance.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int i = 0; i < PLANES; i++) begin
        dist_a3[i] <= plane_prod[i][0] + plane_prod[i][1];
        dist_b3[i] <= plane_prod[i][2] + offr2[i];
      end
      d2a3 <= sq_prod[0][D2_W-1:0] + sq_prod[1][D2_W-1:0];
      d2z3 <= sq_prod[2][D2_W-1:0];
      lim3 <= D2_W'(vd_prod[RR_W-1:0]) + D2_W'(rr_prod[RR_W-1:0]);
      rr3  <= rr_prod[RR_W-1:0];
    end
  end

  always_comb begin
    outside_any = 1'b0;
    for (int i = 0; i < PLANES; i++) begin
      dist_sum[i] = dist_a3[i] + dist_b3[i];
      outside_any = outside_any || dist_sum[i][DIST_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      outside4 <= outside_any;
      d2_4     <= d2a3 + d2z3;
      lim4     <= lim3;
      rr4      <= rr3;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: distance compare and detail-level weights.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      outside5 <= outside4;
      far5     <= d2_4 > lim4;
      above5   <= d2_4 > D2_W'(LOD_FLOOR);
      d2_5     <= d2_4;
      d_k0_5   <= LOD_W'(d2_4) * LOD_W'(LOD_K0);
      d_k1_5   <= LOD_W'(d2_4) * LOD_W'(LOD_K1);
      rr_k_5   <= LOD_W'(rr4) * LOD_W'(LOD_RR_K);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: verdict and detail level into the output register.
  // --------------------------------------------------------------------------
  always_comb begin
    // The floor applies before weighting, so picking the weighted floor is
    // the same as weighting the larger of d2 and the floor.
    m_k0  = above5 ? d_k0_5 : LOD_W'(LOD_FLOOR_K0);
    m_k1  = above5 ? d_k1_5 : LOD_W'(LOD_FLOOR_K1);
    m_one = above5 ? LOD_W'(d2_5) : LOD_W'(LOD_FLOOR);

    if (rr_k_5 > m_k0) begin
      level = 2'd0;
    end else if (rr_k_5 > m_k1) begin
      level = 2'd1;
    end else if (rr_k_5 > m_one) begin
      level = 2'd2;
    end else begin
      level = 2'd3;
    end

    if (hid[SIDE-1]) begin
      verdict_next = VERDICT_LAYER;
    end else if (far5) begin
      verdict_next = VERDICT_FAR;
    end else if (outside5) begin
      verdict_next = VERDICT_FRUSTUM;
    end else begin
      verdict_next = VERDICT_VISIBLE;
    end

    if (verdict_next != VERDICT_VISIBLE) begin
      lod_next = '0;
    end else if (level > mlod[SIDE-1]) begin
      lod_next = mlod[SIDE-1];
    end else begin
      lod_next = level;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[PIPE_STAGES-1]) begin
      res_visible <= (verdict_next == VERDICT_VISIBLE);
      res_lod     <= lod_next;
      res_verdict <= verdict_next;
    end
  end

  assign result.valid   = vld[PIPE_STAGES-1];
  assign result.visible = res_visible;
  assign result.lod     = res_lod;
  assign result.verdict = res_verdict;

endmodule

/* hdl/iclod_mul.sv */
// ----------------------------------------------------------------------------
// Two-stage signed multiplier
// Splits the second operand in halves; partial products, then their sum.
// ----------------------------------------------------------------------------
module iclod_mul (
  input  logic                              clk,
  input  logic                              en_part,
  input  logic                              en_sum,
  input  logic signed [iclod_pkg::MUL_W-1:0]  a,
  input  logic signed [iclod_pkg::MUL_W-1:0]  b,
  output logic signed [iclod_pkg::PROD_W-1:0] p
);
  import iclod_pkg::*;

  localparam int LO_W = MUL_W / 2;
  localparam int HI_W = MUL_W - LO_W;

  // The low half of b is unsigned, so it gets a zero sign bit.
  logic signed [MUL_W+LO_W:0]   part_lo;
  logic signed [MUL_W+HI_W-1:0] part_hi;

  always_ff @(posedge clk) begin
    if (en_part) begin
      part_lo <= a * $signed({1'b0, b[LO_W-1:0]});
      part_hi <= a * $signed(b[MUL_W-1:LO_W]);
    end
    if (en_sum) begin
      p <= (PROD_W'(part_hi) <<< LO_W) + PROD_W'(part_lo);
    end
  end

endmodule

/* hdl/iclod_checker.sv */
// ----------------------------------------------------------------------------
// Instance cull port checker
// Watches the channels of the cull unit for ordering, latency and stall rules.
// ----------------------------------------------------------------------------
module iclod_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_opcode,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            visible,
  input logic [iclod_pkg::LOD_BITS-1:0]  lod,
  input logic [iclod_pkg::VERDICT_W-1:0] verdict
);
  import iclod_pkg::*;

  // A stalled result transaction keeps its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(visible) && $stable(lod) &&
                                $stable(verdict))
    else $error("result payload changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // A result that follows an empty output slot traces back to an accepted test
  // transaction, and only a test transaction makes one.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |->
      $past(in_valid && in_ready && (in_opcode == OP_TEST), PIPE_STAGES))
    else $error("result without matching test transaction");

  // The input side only backs up when the output is stalled.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while result side free");

  // Rejected instances are not drawn and carry full detail.
  a_verdict_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (visible == (verdict == VERDICT_VISIBLE)) &&
                  ((verdict == VERDICT_VISIBLE) || (lod == '0)))
    else $error("result fields disagree with verdict");

endmodule

bind instance_cull_lod_select_unit iclod_checker u_iclod_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (inst.valid),
  .in_ready  (inst.ready),
  .in_opcode (inst.opcode),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .visible   (result.visible),
  .lod       (result.lod),
  .verdict   (result.verdict)
);
